### rtl/ahs_pkg.sv
// ---------------------------------------------------------------------------
// ahs_pkg: shared constants and types of the aging hash set.
// Command codes, default sizes and the lookup result bundle.
// ---------------------------------------------------------------------------
`default_nettype none
package ahs_pkg;
    localparam int NUM_BUCKETS_DEF = 256;
    localparam int WAYS_DEF        = 4;
    localparam int KEY_BITS_DEF    = 32;
    localparam int STAMP_BITS_DEF  = 32;
    localparam int CNT_W           = 11;
    localparam logic [31:0] MAX_AGE_RST = 32'd8;

    localparam logic [2:0] CMD_ADD      = 3'd0;
    localparam logic [2:0] CMD_CONTAINS = 3'd1;
    localparam logic [2:0] CMD_AGE      = 3'd2;
    localparam logic [2:0] CMD_CLEAR    = 3'd3;
    localparam logic [2:0] CMD_COUNT    = 3'd4;

    typedef struct packed {
        logic found;
        logic inserted;
        logic bucket_full;
        logic [CNT_W-1:0] removed_count;
        logic [CNT_W-1:0] entry_count;
    } t_result;
endpackage
`default_nettype wire

### rtl/ahs_ram.sv
// ---------------------------------------------------------------------------
// ahs_ram: generic single-port-write, single-read RAM.
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none
module ahs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

### rtl/aging_hash_set_top.sv
// ---------------------------------------------------------------------------
// aging_hash_set_top: bucketed hash set of keys with time stamp aging.
//
// Commands arrive on the s_axis channel, tdata = {time_stamp, key, cmd}
// from cmd upward. Each command gives one result on m_axis. Bucket rows
// of WAYS slots sit in two RAMs (keys, stamps), one row per address; the
// row valid mask lives in a third RAM. Add and contains read one row and
// write it back; the result follows the read, update and output states.
// Age-out sweeps every row through the memory read port and writes back its
// valid mask without the aged slots; clear writes zero masks to every row.
// Count and unknown codes go straight to the output state.
// After reset a clearing pass over every row zeros the valid masks; no
// command is taken during it; max_age writes are taken outside reset.
// The block works on one command at a time. A result waits in the output
// register while m_axis_tready is low, and s_axis_tready stays low until
// that register is free, so with a ready receiver the next command can be
// taken in the cycle after the result transaction.
// ---------------------------------------------------------------------------
`default_nettype none
module aging_hash_set_top #(
    parameter int NUM_BUCKETS = ahs_pkg::NUM_BUCKETS_DEF,
    parameter int WAYS        = ahs_pkg::WAYS_DEF,
    parameter int KEY_BITS    = ahs_pkg::KEY_BITS_DEF,
    parameter int STAMP_BITS  = ahs_pkg::STAMP_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // cmd[2:0], key[34:3], time_stamp[66:35], zero pad to 72 bits
    input  wire logic [71:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // found[0], inserted[1], bucket_full[2], removed_count[13:3],
    // entry_count[24:14], zero pad to 32 bits
    output logic [31:0]      m_axis_tdata,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [31:0] i_cfg_data
);
    localparam int AW  = $clog2(NUM_BUCKETS);
    localparam int CW  = ahs_pkg::CNT_W;
    localparam int KW  = (KEY_BITS < 32) ? KEY_BITS : 32;
    localparam int SW  = (STAMP_BITS < 32) ? STAMP_BITS : 32;
    localparam int WW  = $clog2(WAYS + 1);

    typedef enum logic [5:0] {
        S_CLR  = 6'b000001,
        S_IDLE = 6'b000010,
        S_RD   = 6'b000100,
        S_UPD  = 6'b001000,
        S_SWP  = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic [31:0] r_max_age;
    logic [2:0]  r_cmd;
    logic [KW-1:0] r_key;
    logic [SW-1:0] r_now;
    logic [AW:0]   r_addr, n_addr;
    logic [CW-1:0] r_count, n_count, r_removed, n_removed;
    ahs_pkg::t_result r_res, n_res;
    logic r_ovalid, n_ovalid;
    logic r_rdv, n_rdv;

    logic we;
    logic [AW-1:0] waddr, raddr;
    logic [WAYS-1:0] wvalid, rvalid;
    logic [WAYS*KW-1:0] wkey, rkey;
    logic [WAYS*SW-1:0] wstamp, rstamp;
    logic kwe, swe;

    ahs_ram #(.WIDTH(WAYS), .DEPTH(NUM_BUCKETS)) u_valid (
        .i_clk, .i_we(we), .i_waddr(waddr), .i_wdata(wvalid),
        .i_raddr(raddr), .o_rdata(rvalid));
    ahs_ram #(.WIDTH(WAYS*KW), .DEPTH(NUM_BUCKETS)) u_key (
        .i_clk, .i_we(kwe), .i_waddr(waddr), .i_wdata(wkey),
        .i_raddr(raddr), .o_rdata(rkey));
    ahs_ram #(.WIDTH(WAYS*SW), .DEPTH(NUM_BUCKETS)) u_stamp (
        .i_clk, .i_we(swe), .i_waddr(waddr), .i_wdata(wstamp),
        .i_raddr(raddr), .o_rdata(rstamp));

    wire accept = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && !r_ovalid;
    assign o_cfg_ready = 1'b1;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata = {7'd0, r_res.entry_count, r_res.removed_count,
                           r_res.bucket_full, r_res.inserted, r_res.found};

    logic [AW-1:0] bucket_in;
    assign bucket_in = AW'(s_axis_tdata[3 +: KW]);

    logic hit, has_free;
    logic [WAYS-1:0] hit_vec, free_vec, old_vec;
    logic [WW-1:0] nold;
    logic [SW-1:0] age;

    always_comb begin
        hit = 1'b0;
        has_free = 1'b0;
        hit_vec = '0;
        free_vec = '0;
        old_vec = '0;
        nold = '0;
        age = '0;
        for (int w = 0; w < WAYS; w++) begin
            age = r_now - rstamp[w*SW +: SW];
            if (rvalid[w] && (32'(age) > r_max_age)) begin
                old_vec[w] = 1'b1;
                nold = nold + WW'(1);
            end
        end
        for (int w = 0; w < WAYS; w++) begin
            if (rvalid[w] && !hit && rkey[w*KW +: KW] == r_key) begin
                hit = 1'b1;
                hit_vec[w] = 1'b1;
            end else if (!rvalid[w] && !has_free) begin
                has_free = 1'b1;
                free_vec[w] = 1'b1;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_addr = r_addr;
        n_count = r_count;
        n_removed = r_removed;
        n_res = r_res;
        n_ovalid = r_ovalid && !m_axis_tready;
        n_rdv = 1'b0;
        we = 1'b0;
        kwe = 1'b0;
        swe = 1'b0;
        waddr = r_addr[AW-1:0];
        raddr = r_addr[AW-1:0];
        wvalid = '0;
        wkey = rkey;
        wstamp = rstamp;
        unique case (r_state)
            S_CLR: begin
                we = 1'b1;
                n_addr = r_addr + (AW+1)'(1);
                if (r_addr == (AW+1)'(NUM_BUCKETS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                raddr = bucket_in;
                if (accept) begin
                    n_res = '0;
                    n_addr = '0;
                    n_removed = '0;
                    priority if (s_axis_tdata[2:0] == ahs_pkg::CMD_ADD ||
                                 s_axis_tdata[2:0] == ahs_pkg::CMD_CONTAINS) begin
                        n_addr = (AW+1)'(bucket_in);
                        n_state = S_RD;
                    end else if (s_axis_tdata[2:0] == ahs_pkg::CMD_AGE) begin
                        raddr = '0;
                        n_rdv = 1'b1;
                        n_addr = (AW+1)'(1);
                        n_state = S_SWP;
                    end else if (s_axis_tdata[2:0] == ahs_pkg::CMD_CLEAR) begin
                        n_removed = r_count;
                        n_state = S_SWP;
                    end else begin
                        n_state = S_OUT;
                    end
                end
            end
            S_RD: n_state = S_UPD;
            S_UPD: begin
                we = 1'b1;
                wvalid = rvalid;
                n_state = S_OUT;
                if (hit) begin
                    n_res.found = 1'b1;
                    if (r_cmd == ahs_pkg::CMD_ADD) begin
                        swe = 1'b1;
                        for (int w = 0; w < WAYS; w++)
                            if (hit_vec[w]) wstamp[w*SW +: SW] = r_now;
                    end
                end else if (r_cmd == ahs_pkg::CMD_ADD) begin
                    if (has_free) begin
                        kwe = 1'b1;
                        swe = 1'b1;
                        wvalid = rvalid | free_vec;
                        for (int w = 0; w < WAYS; w++)
                            if (free_vec[w]) begin
                                wkey[w*KW +: KW] = r_key;
                                wstamp[w*SW +: SW] = r_now;
                            end
                        n_count = r_count + CW'(1);
                        n_res.inserted = 1'b1;
                    end else begin
                        n_res.bucket_full = 1'b1;
                    end
                end
            end
            S_SWP: begin
                if (r_cmd == ahs_pkg::CMD_CLEAR) begin
                    we = 1'b1;
                    waddr = r_addr[AW-1:0];
                    n_addr = r_addr + (AW+1)'(1);
                    if (r_addr == (AW+1)'(NUM_BUCKETS - 1)) begin
                        n_count = '0;
                        n_state = S_OUT;
                    end
                end else begin
                    raddr = r_addr[AW-1:0];
                    waddr = AW'(r_addr - (AW+1)'(1));
                    we = r_rdv;
                    wvalid = rvalid & ~old_vec;
                    if (r_rdv) n_removed = r_removed + CW'(nold);
                    if (r_addr == (AW+1)'(NUM_BUCKETS)) begin
                        n_count = r_count - (r_removed + CW'(nold));
                        n_state = S_OUT;
                    end else begin
                        n_rdv = 1'b1;
                        n_addr = r_addr + (AW+1)'(1);
                    end
                end
            end
            S_OUT: begin
                n_res.removed_count = r_removed;
                n_res.entry_count = r_count;
                n_ovalid = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_addr <= '0;
            r_count <= '0;
            r_ovalid <= 1'b0;
            r_rdv <= 1'b0;
            r_max_age <= ahs_pkg::MAX_AGE_RST;
        end else begin
            r_state <= n_state;
            r_addr <= n_addr;
            r_count <= n_count;
            r_ovalid <= n_ovalid;
            r_rdv <= n_rdv;
            if (i_cfg_valid) r_max_age <= i_cfg_data;
        end
        r_removed <= n_removed;
        r_res <= n_res;
        if (accept) begin
            r_cmd <= s_axis_tdata[2:0];
            r_key <= s_axis_tdata[3 +: KW];
            r_now <= s_axis_tdata[35 +: SW];
        end
    end

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> !s_axis_tready)
        else $error("command taken while a result waits");
    a_one_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> $onehot0({r_res.inserted, r_res.bucket_full, r_res.found}))
        else $error("conflicting add flags");
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(NUM_BUCKETS * WAYS))
        else $error("entry count too large");
endmodule
`default_nettype wire

### tb/sv/tb_aging_hash_set_top.sv
// ---------------------------------------------------------------------------
// tb_aging_hash_set_top: self-checking bench for the aging hash set.
// Commands go in on the s_axis stream and results come back on m_axis.
// A behavioral copy of the table predicts each result. The bench runs a
// directed part and long random parts, most with sender and receiver stalls.
// ---------------------------------------------------------------------------
module tb_aging_hash_set_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NB = ahs_pkg::NUM_BUCKETS_DEF;
    localparam int NW = ahs_pkg::WAYS_DEF;
    localparam int NSLOT = NB * NW;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_data = '0;

    aging_hash_set_top u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_data(i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    logic        tbl_valid [NSLOT];
    logic [31:0] tbl_key   [NSLOT];
    logic [31:0] tbl_stamp [NSLOT];
    logic [10:0] tbl_count;
    logic [31:0] age_limit;

    ahs_pkg::t_result expected_results [$];
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          errors = 0;
    int          result_total = 0;
    int          full_total = 0;
    int          removed_total = 0;
    logic [31:0] live_keys [$];
    event        start_hold;
    logic        receiver_held = 1'b0;

    function automatic ahs_pkg::t_result predict_command(logic [2:0] cmd, logic [31:0] key,
                                                         logic [31:0] now);
        ahs_pkg::t_result r;
        int base;
        int hit;
        int free_slot;
        r = '0;
        base = int'(key % 32'(NB)) * NW;
        if (cmd == ahs_pkg::CMD_ADD || cmd == ahs_pkg::CMD_CONTAINS) begin
            hit = -1;
            free_slot = -1;
            for (int w = 0; w < NW; w++) begin
                if (tbl_valid[base+w]) begin
                    if (hit < 0 && tbl_key[base+w] == key) hit = base + w;
                end else if (free_slot < 0) begin
                    free_slot = base + w;
                end
            end
            if (hit >= 0) begin
                r.found = 1'b1;
                if (cmd == ahs_pkg::CMD_ADD) tbl_stamp[hit] = now;
            end else if (cmd == ahs_pkg::CMD_ADD) begin
                if (free_slot >= 0) begin
                    tbl_valid[free_slot] = 1'b1;
                    tbl_key[free_slot] = key;
                    tbl_stamp[free_slot] = now;
                    tbl_count++;
                    r.inserted = 1'b1;
                end else begin
                    r.bucket_full = 1'b1;
                end
            end
        end else if (cmd == ahs_pkg::CMD_AGE) begin
            for (int s = 0; s < NSLOT; s++) begin
                if (tbl_valid[s] && (now - tbl_stamp[s]) > age_limit) begin
                    tbl_valid[s] = 1'b0;
                    r.removed_count++;
                end
            end
            tbl_count -= r.removed_count;
        end else if (cmd == ahs_pkg::CMD_CLEAR) begin
            r.removed_count = tbl_count;
            for (int s = 0; s < NSLOT; s++) tbl_valid[s] = 1'b0;
            tbl_count = '0;
        end
        r.entry_count = tbl_count;
        return r;
    endfunction

    task automatic send_command(logic [2:0] cmd, logic [31:0] key, logic [31:0] now);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {5'd0, now, key, cmd};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        expected_results.push_back(predict_command(cmd, key, now));
        if (cmd == ahs_pkg::CMD_ADD) live_keys.push_back(key);
        if (live_keys.size() > 64) void'(live_keys.pop_front());
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (NB + 8) @(posedge i_clk);
    endtask

    task automatic write_max_age(logic [31:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        age_limit = value;
    endtask

    initial begin
        forever begin
            @(start_hold);
            receiver_held = 1'b1;
            repeat (400) @(posedge i_clk);
            receiver_held = 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                ahs_pkg::t_result got;
                ahs_pkg::t_result want;
                got = '{found: m_axis_tdata[0], inserted: m_axis_tdata[1],
                        bucket_full: m_axis_tdata[2], removed_count: m_axis_tdata[13:3],
                        entry_count: m_axis_tdata[24:14]};
                result_total++;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, actual %h", $time, m_axis_tdata);
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    full_total += want.bucket_full;
                    removed_total += want.removed_count;
                    if (got.found !== want.found || got.inserted !== want.inserted ||
                        got.bucket_full !== want.bucket_full ||
                        got.removed_count !== want.removed_count ||
                        got.entry_count !== want.entry_count ||
                        m_axis_tdata[31:25] !== 7'd0) begin
                        $display("%0t: mismatch, expected f%b i%b b%b rm%0d n%0d, actual %h",
                                 $time, want.found, want.inserted, want.bucket_full,
                                 want.removed_count, want.entry_count, m_axis_tdata);
                        errors++;
                    end
                end
            end
            if (receiver_held) begin
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
            end
        end
    end

    task automatic test_directed();
        write_max_age(32'd0);
        send_command(ahs_pkg::CMD_COUNT, 32'h0, 32'h0);
        send_command(ahs_pkg::CMD_CONTAINS, 32'hFFFF_FFFF, 32'h0);
        send_command(ahs_pkg::CMD_ADD, 32'h0000_0000, 32'h0);
        send_command(ahs_pkg::CMD_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_command(ahs_pkg::CMD_ADD, 32'h0000_0000, 32'h5);
        for (int w = 0; w < NW + 1; w++)
            send_command(ahs_pkg::CMD_ADD, {24'(w + 1), 8'h11}, 32'hAAAA_5555);
        send_command(ahs_pkg::CMD_CONTAINS, 32'h0000_0111, 32'h0);
        send_command(ahs_pkg::CMD_CONTAINS, 32'h0000_0511, 32'h0);
        send_command(3'd5, 32'h1, 32'h1);
        send_command(3'd6, 32'h2, 32'h2);
        send_command(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_command(ahs_pkg::CMD_AGE, 32'h0, 32'h5);
        send_command(ahs_pkg::CMD_AGE, 32'h0, 32'h0000_0003);
        send_command(ahs_pkg::CMD_CLEAR, 32'h0, 32'h0);
        send_command(ahs_pkg::CMD_CLEAR, 32'h0, 32'h0);
        wait_drained();
        write_max_age(32'hFFFF_FFFF);
        send_command(ahs_pkg::CMD_ADD, 32'h1234_5600, 32'hFFFF_FFF0);
        send_command(ahs_pkg::CMD_AGE, 32'h0, 32'h0000_0010);
        send_command(ahs_pkg::CMD_COUNT, 32'h0, 32'h0);
        wait_drained();
    endtask

    task automatic random_phase(int n, logic [31:0] max_age_val, int sidle, int ridle);
        logic [31:0] now;
        logic [31:0] key;
        int pick;
        wait_drained();
        write_max_age(max_age_val);
        send_idle_pct = sidle;
        recv_idle_pct = ridle;
        now = $urandom();
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(99);
            now += $urandom_range(3);
            if (pick < 20 && live_keys.size() > 0)
                key = live_keys[$urandom_range(live_keys.size() - 1)];
            else if (pick < 40)
                key = {2'($urandom_range(3)), 22'd0, 8'($urandom_range(7))};
            else
                key = $urandom();
            pick = $urandom_range(99);
            if (pick < 50)      send_command(ahs_pkg::CMD_ADD, key, now);
            else if (pick < 80) send_command(ahs_pkg::CMD_CONTAINS, key, now);
            else if (pick < 88) send_command(ahs_pkg::CMD_AGE, $urandom(), now);
            else if (pick < 91) send_command(ahs_pkg::CMD_CLEAR, $urandom(), $urandom());
            else if (pick < 96) send_command(ahs_pkg::CMD_COUNT, $urandom(), $urandom());
            else                send_command(3'($urandom_range(7, 5)), $urandom(), $urandom());
        end
    endtask

    task automatic test_backpressure();
        wait_drained();
        -> start_hold;
        for (int i = 0; i < 20; i++) send_command(ahs_pkg::CMD_ADD, $urandom(), 32'h77);
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (expected_results.size() != 0);
        send_command(ahs_pkg::CMD_COUNT, 32'h0, 32'h0);
    endtask

    initial begin
        for (int s = 0; s < NSLOT; s++) begin
            tbl_valid[s] = 1'b0;
            tbl_key[s] = '0;
            tbl_stamp[s] = '0;
        end
        tbl_count = '0;
        age_limit = ahs_pkg::MAX_AGE_RST;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        random_phase(580, 32'd8, 35, 45);
        random_phase(580, 32'd40, 45, 35);
        random_phase(580, 32'd2, 0, 0);
        test_backpressure();
        wait_drained();
        $display("Covered %0d results, %0d full-bucket drops, %0d entries aged or cleared.",
                 result_total, full_total, removed_total);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Timeout waiting for results.");
        $display("Test completed with failures");
        $finish;
    end
endmodule

### sim.f
rtl/ahs_pkg.sv
rtl/ahs_ram.sv
rtl/aging_hash_set_top.sv
tb/sv/tb_aging_hash_set_top.sv
